// ===== hdl/obd2pr_pkg.sv =====
// ----------------------------------------------------------------------------
// obd2pr_pkg
// Types, codes and constants shared by the OBD-II PID request responder.
// ----------------------------------------------------------------------------
package obd2pr_pkg;

  // configuration port
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_MODULE_VOLTAGE = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_UNSUPP_FILL    = 8'd1;

  localparam logic [15:0] VOLTAGE_RESET = 16'd7670;
  localparam logic [7:0]  FILL_RESET    = 8'd170;

  // request length codes
  localparam logic [7:0] LEN_SHORT = 8'h02;
  localparam logic [7:0] LEN_EXT   = 8'h03;

  // service modes
  localparam logic [7:0] MODE_CURRENT = 8'h01;
  localparam logic [7:0] MODE_VEHINFO = 8'h09;
  localparam logic [7:0] MODE_EXT     = 8'h22;

  // reply modes
  localparam logic [7:0] RSP_MODE01 = 8'h41;
  localparam logic [7:0] RSP_MODE22 = 8'h62;

  // reply length codes
  localparam logic [7:0] RLEN_ONE    = 8'h03;
  localparam logic [7:0] RLEN_TWO    = 8'h04;
  localparam logic [7:0] RLEN_THREE  = 8'h05;
  localparam logic [7:0] RLEN_BITMAP = 8'h06;

  // mode 01 pids
  localparam logic [7:0] PID_SUPP_00  = 8'h00;
  localparam logic [7:0] PID_SUPP_20  = 8'h20;
  localparam logic [7:0] PID_SUPP_40  = 8'h40;
  localparam logic [7:0] PID_SUPP_60  = 8'h60;
  localparam logic [7:0] PID_SUPP_80  = 8'h80;
  localparam logic [7:0] PID_COOLANT  = 8'h05;
  localparam logic [7:0] PID_FUEL_P   = 8'h0A;
  localparam logic [7:0] PID_MAP      = 8'h0B;
  localparam logic [7:0] PID_RPM      = 8'h0C;
  localparam logic [7:0] PID_SPEED    = 8'h0D;
  localparam logic [7:0] PID_IAT      = 8'h0F;
  localparam logic [7:0] PID_THROTTLE = 8'h11;
  localparam logic [7:0] PID_RAIL     = 8'h22;
  localparam logic [7:0] PID_VOLTAGE  = 8'h42;
  localparam logic [7:0] PID_OIL      = 8'h5C;

  // mode 09 pid
  localparam logic [7:0] PID_VIN_SUPP = 8'h00;

  // mode 22 pids
  localparam logic [7:0] EXT_HI_A  = 8'h14;
  localparam logic [7:0] EXT_LO_A  = 8'h10;
  localparam logic [7:0] EXT_HI_B  = 8'h40;
  localparam logic [7:0] EXT_LO_B0 = 8'h2B;
  localparam logic [7:0] EXT_LO_B1 = 8'h30;
  localparam logic [7:0] EXT_DATA_B = 8'h7F;

  // supported-pid bitmaps, byte A first
  localparam logic [31:0] SUPP_MAP_00 = 32'h087A_8001;
  localparam logic [31:0] SUPP_MAP_20 = 32'h4000_0001;
  localparam logic [31:0] SUPP_MAP_40 = 32'h0000_0011;
  localparam logic [31:0] SUPP_MAP_60 = 32'h0000_0001;
  localparam logic [31:0] SUPP_MAP_80 = 32'h0000_0000;

  // temperature offset and map pressure offset
  localparam logic [7:0]        TEMP_OFS  = 8'd40;
  localparam logic [7:0]        MAP_OFS   = 8'd101;
  localparam logic signed [7:0] MAP_FLOOR = -8'sd101;

  // floor(x/3) = (x * 43691) >> 17, exact for 16-bit x
  localparam logic [16:0] DIV3_MUL   = 17'd43691;
  localparam int unsigned DIV3_SHIFT = 17;

  // floor(p*1000/79) = (p * ceil(2^20*1000/79)) >> 20 for p below the limit
  localparam int unsigned RailPW     = 13;
  localparam logic [23:0] RAIL_MUL   = 24'd13273114;
  localparam int unsigned RAIL_SHIFT = 20;
  localparam logic [15:0] RAIL_LIMIT = 16'd5178;

  typedef struct packed {
    logic [7:0]        req_len;
    logic [7:0]        req_mode;
    logic [7:0]        req_pid_high;
    logic [7:0]        req_pid_low;
    logic signed [7:0] manifold_gauge_kpa;
    logic [15:0]       engine_rpm;
    logic [7:0]        vehicle_speed;
    logic [7:0]        throttle_pos;
    logic [7:0]        coolant_raw;
    logic [7:0]        oil_raw;
    logic [15:0]       fuel_pressure;
    logic [7:0]        intake_air_raw;
  } req_t;

  typedef struct packed {
    logic [7:0] resp_byte0;
    logic [7:0] resp_byte1;
    logic [7:0] resp_byte2;
    logic [7:0] resp_byte3;
    logic [7:0] resp_byte4;
    logic [7:0] resp_byte5;
    logic [7:0] resp_byte6;
    logic [7:0] resp_byte7;
  } resp_t;

  typedef struct packed {
    logic [15:0] module_voltage_mv;
    logic [7:0]  unsupported_fill;
  } cfg_regs_t;

endpackage

// ===== hdl/obd2pr_if.sv =====
// ----------------------------------------------------------------------------
// obd2pr_if
// Valid/ready channels of the responder: request, reply and register write.
// ----------------------------------------------------------------------------
interface obd2pr_req_if import obd2pr_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface obd2pr_resp_if import obd2pr_pkg::*; ();
  logic  valid;
  logic  ready;
  resp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface obd2pr_cfg_if import obd2pr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/obd2pr_encoder.sv =====
// ----------------------------------------------------------------------------
// obd2pr_encoder
// Decodes one request and builds the 8-byte reply from the sensor values.
// ----------------------------------------------------------------------------
module obd2pr_encoder import obd2pr_pkg::*; (
  input  req_t      req_i,
  input  cfg_regs_t cfg_i,
  output resp_t     rsp_o
);

  logic [32:0]           div3_prod;
  logic [7:0]            fuel_byte;
  logic [36:0]           rail_prod;
  logic [15:0]           rail;
  logic [7:0]            map_byte;
  logic [RailPW-1:0]     rail_p;

  assign div3_prod = 33'(req_i.fuel_pressure) * 33'(DIV3_MUL);
  assign fuel_byte = div3_prod[DIV3_SHIFT+7:DIV3_SHIFT];

  // saturation covers every pressure at or above the limit
  assign rail_p    = req_i.fuel_pressure[RailPW-1:0];
  assign rail_prod = 37'(rail_p) * 37'(RAIL_MUL);
  assign rail      = (req_i.fuel_pressure >= RAIL_LIMIT) ? 16'hFFFF :
                     rail_prod[RAIL_SHIFT+15:RAIL_SHIFT];

  assign map_byte  = (req_i.manifold_gauge_kpa <= MAP_FLOOR) ? 8'd0 :
                     8'(req_i.manifold_gauge_kpa) + MAP_OFS;

  always_comb begin
    rsp_o = '0;
    if (req_i.req_len == LEN_SHORT && req_i.req_mode == MODE_CURRENT) begin
      rsp_o.resp_byte1 = RSP_MODE01;
      rsp_o.resp_byte2 = req_i.req_pid_high;
      rsp_o.resp_byte0 = RLEN_ONE;
      case (req_i.req_pid_high)
        PID_SUPP_00: begin
          rsp_o.resp_byte0 = RLEN_BITMAP;
          {rsp_o.resp_byte3, rsp_o.resp_byte4, rsp_o.resp_byte5, rsp_o.resp_byte6} =
            SUPP_MAP_00;
        end
        PID_SUPP_20: begin
          rsp_o.resp_byte0 = RLEN_BITMAP;
          {rsp_o.resp_byte3, rsp_o.resp_byte4, rsp_o.resp_byte5, rsp_o.resp_byte6} =
            SUPP_MAP_20;
        end
        PID_SUPP_40: begin
          rsp_o.resp_byte0 = RLEN_BITMAP;
          {rsp_o.resp_byte3, rsp_o.resp_byte4, rsp_o.resp_byte5, rsp_o.resp_byte6} =
            SUPP_MAP_40;
        end
        PID_SUPP_60: begin
          rsp_o.resp_byte0 = RLEN_BITMAP;
          {rsp_o.resp_byte3, rsp_o.resp_byte4, rsp_o.resp_byte5, rsp_o.resp_byte6} =
            SUPP_MAP_60;
        end
        PID_SUPP_80: begin
          rsp_o.resp_byte0 = RLEN_BITMAP;
          {rsp_o.resp_byte3, rsp_o.resp_byte4, rsp_o.resp_byte5, rsp_o.resp_byte6} =
            SUPP_MAP_80;
        end
        PID_COOLANT:  rsp_o.resp_byte3 = req_i.coolant_raw + TEMP_OFS;
        PID_FUEL_P:   rsp_o.resp_byte3 = fuel_byte;
        PID_MAP:      rsp_o.resp_byte3 = map_byte;
        PID_RPM: begin
          rsp_o.resp_byte0 = RLEN_TWO;
          {rsp_o.resp_byte3, rsp_o.resp_byte4} = {req_i.engine_rpm[13:0], 2'b00};
        end
        PID_SPEED:    rsp_o.resp_byte3 = req_i.vehicle_speed;
        PID_IAT:      rsp_o.resp_byte3 = req_i.intake_air_raw + TEMP_OFS;
        PID_THROTTLE: rsp_o.resp_byte3 = req_i.throttle_pos;
        PID_RAIL: begin
          rsp_o.resp_byte0 = RLEN_TWO;
          {rsp_o.resp_byte3, rsp_o.resp_byte4} = rail;
        end
        PID_VOLTAGE: begin
          rsp_o.resp_byte0 = RLEN_TWO;
          {rsp_o.resp_byte3, rsp_o.resp_byte4} = cfg_i.module_voltage_mv;
        end
        PID_OIL:      rsp_o.resp_byte3 = req_i.oil_raw + TEMP_OFS;
        default: begin
          rsp_o.resp_byte0 = RLEN_TWO;
          rsp_o.resp_byte3 = cfg_i.unsupported_fill;
          rsp_o.resp_byte4 = cfg_i.unsupported_fill;
        end
      endcase
    end else if (req_i.req_len == LEN_SHORT && req_i.req_mode == MODE_VEHINFO &&
                 req_i.req_pid_high == PID_VIN_SUPP) begin
      rsp_o.resp_byte0 = RLEN_TWO;
    end else if (req_i.req_mode == MODE_EXT) begin
      rsp_o.resp_byte0 = RLEN_TWO;
      rsp_o.resp_byte1 = RSP_MODE22;
      rsp_o.resp_byte2 = req_i.req_pid_high;
      rsp_o.resp_byte3 = req_i.req_pid_low;
      if (req_i.req_len == LEN_EXT && req_i.req_pid_high == EXT_HI_A &&
          req_i.req_pid_low == EXT_LO_A) begin
        rsp_o.resp_byte0 = RLEN_THREE;
      end else if (req_i.req_len == LEN_EXT && req_i.req_pid_high == EXT_HI_B &&
                   (req_i.req_pid_low inside {EXT_LO_B0, EXT_LO_B1})) begin
        rsp_o.resp_byte4 = EXT_DATA_B;
      end
    end else begin
      rsp_o.resp_byte0 = RLEN_TWO;
      rsp_o.resp_byte1 = req_i.req_mode;
      rsp_o.resp_byte2 = req_i.req_pid_high;
      rsp_o.resp_byte3 = req_i.req_pid_low;
    end
  end

endmodule

// ===== hdl/obd2_pid_request_responder_unit.sv =====
// ----------------------------------------------------------------------------
// obd2_pid_request_responder_unit
// OBD-II responder: one request word in, one 8-byte reply word out.
//
//   channel  dir  modport  payload
//   req_i    in   sink     request bytes 0..3 and sensor values
//   resp_o   out  source   reply bytes 0..7
//   cfg_i    in   sink     register index and write data
//
// One word per cycle sustained while the reply side is ready; a request
// passes the request register, then is decoded into the reply register.
// The reply register stalling holds the request register; a new request
// is still taken while the reply register waits, as long as one slot is free.
// Reset empties both stages and loads the register defaults.
// Register writes are always accepted.
// ----------------------------------------------------------------------------
module obd2_pid_request_responder_unit import obd2pr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  obd2pr_req_if.sink   req_i,
  obd2pr_resp_if.source resp_o,
  obd2pr_cfg_if.sink   cfg_i
);

  logic      in_v_q;
  req_t      req_q;
  logic      out_v_q;
  resp_t     rsp_q;
  resp_t     rsp_d;
  cfg_regs_t cfg_q;
  logic      out_adv;
  logic      req_take;
  logic      cfg_wr;

  assign out_adv     = !out_v_q || resp_o.ready;
  assign req_i.ready = !in_v_q || out_adv;
  assign req_take    = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;
  assign cfg_wr      = cfg_i.valid && cfg_i.ready;

  assign resp_o.valid = out_v_q;
  assign resp_o.data  = rsp_q;

  obd2pr_encoder u_encoder (
    .req_i (req_q),
    .cfg_i (cfg_q),
    .rsp_o (rsp_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (req_i.ready) begin
        in_v_q <= req_i.valid;
      end
      if (out_adv) begin
        out_v_q <= in_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_take) begin
      req_q <= req_i.data;
    end
    if (out_adv && in_v_q) begin
      rsp_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.module_voltage_mv <= VOLTAGE_RESET;
      cfg_q.unsupported_fill  <= FILL_RESET;
    end else if (cfg_wr) begin
      case (cfg_i.index)
        CFG_MODULE_VOLTAGE: cfg_q.module_voltage_mv <= cfg_i.data;
        CFG_UNSUPP_FILL:    cfg_q.unsupported_fill  <= cfg_i.data[7:0];
        default: ;
      endcase
    end
  end

  // a held request word stays put until the reply register frees up
  a_req_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_v_q && !out_adv) |=> (in_v_q && $stable(req_q)))
    else $error("request stage lost or changed while stalled");

  a_take_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_take |=> in_v_q)
    else $error("accepted request not registered");

  a_byte7_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (rsp_q.resp_byte7 == 8'd0))
    else $error("reply byte 7 not zero");

  a_len_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (rsp_q.resp_byte0 == RLEN_ONE || rsp_q.resp_byte0 == RLEN_TWO ||
                 rsp_q.resp_byte0 == RLEN_THREE || rsp_q.resp_byte0 == RLEN_BITMAP))
    else $error("reply length byte out of set");

  a_cfg_volt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_wr && cfg_i.index == CFG_MODULE_VOLTAGE) |=>
      (cfg_q.module_voltage_mv == $past(cfg_i.data)))
    else $error("voltage register write lost");

endmodule

// ===== bench/obd2pr_reply_checker.sv =====
// ----------------------------------------------------------------------------
// obd2pr_reply_checker
// Watches the request, reply and register channels of the OBD-II responder.
// Every accepted request is turned into the expected 8-byte reply with the
// register values in force. Each accepted reply is compared byte by byte
// with the oldest expected reply.
// ----------------------------------------------------------------------------
module obd2pr_reply_checker import obd2pr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  obd2pr_req_if       req_mon,
  obd2pr_resp_if      resp_mon,
  obd2pr_cfg_if       cfg_mon,
  output int unsigned outstanding_o,
  output int unsigned mismatches_o
);

  resp_t     reply_q[$];
  cfg_regs_t regs;

  function automatic resp_t predict_reply(input req_t rq, input cfg_regs_t cur);
    resp_t       r;
    int          map_kpa;
    int          map_sum;
    logic [15:0] fp_third;
    logic [15:0] rpm_x4;
    logic [31:0] rail;
    r = '0;
    if (rq.req_len == LEN_SHORT && rq.req_mode == MODE_CURRENT) begin
      r.resp_byte1 = RSP_MODE01;
      r.resp_byte2 = rq.req_pid_high;
      case (rq.req_pid_high)
        PID_SUPP_00: begin
          {r.resp_byte3, r.resp_byte4, r.resp_byte5, r.resp_byte6} = SUPP_MAP_00;
          r.resp_byte0 = RLEN_BITMAP;
        end
        PID_SUPP_20: begin
          {r.resp_byte3, r.resp_byte4, r.resp_byte5, r.resp_byte6} = SUPP_MAP_20;
          r.resp_byte0 = RLEN_BITMAP;
        end
        PID_SUPP_40: begin
          {r.resp_byte3, r.resp_byte4, r.resp_byte5, r.resp_byte6} = SUPP_MAP_40;
          r.resp_byte0 = RLEN_BITMAP;
        end
        PID_SUPP_60: begin
          {r.resp_byte3, r.resp_byte4, r.resp_byte5, r.resp_byte6} = SUPP_MAP_60;
          r.resp_byte0 = RLEN_BITMAP;
        end
        PID_SUPP_80: begin
          {r.resp_byte3, r.resp_byte4, r.resp_byte5, r.resp_byte6} = SUPP_MAP_80;
          r.resp_byte0 = RLEN_BITMAP;
        end
        PID_COOLANT: begin
          r.resp_byte0 = RLEN_ONE;
          r.resp_byte3 = rq.coolant_raw + TEMP_OFS;
        end
        PID_FUEL_P: begin
          fp_third = rq.fuel_pressure / 16'd3;
          r.resp_byte0 = RLEN_ONE;
          r.resp_byte3 = fp_third[7:0];
        end
        PID_MAP: begin
          // gauge is signed; anything at or below the floor reads as zero
          map_kpa = $signed(rq.manifold_gauge_kpa);
          map_sum = map_kpa + int'(MAP_OFS);
          r.resp_byte0 = RLEN_ONE;
          r.resp_byte3 = (map_kpa <= int'(MAP_FLOOR)) ? 8'h00 : map_sum[7:0];
        end
        PID_RPM: begin
          rpm_x4 = {rq.engine_rpm[13:0], 2'b00};
          r.resp_byte0 = RLEN_TWO;
          {r.resp_byte3, r.resp_byte4} = rpm_x4;
        end
        PID_SPEED: begin
          r.resp_byte0 = RLEN_ONE;
          r.resp_byte3 = rq.vehicle_speed;
        end
        PID_IAT: begin
          r.resp_byte0 = RLEN_ONE;
          r.resp_byte3 = rq.intake_air_raw + TEMP_OFS;
        end
        PID_THROTTLE: begin
          r.resp_byte0 = RLEN_ONE;
          r.resp_byte3 = rq.throttle_pos;
        end
        PID_RAIL: begin
          rail = (32'(rq.fuel_pressure) * 32'd1000) / 32'd79;
          if (rail > 32'hFFFF) begin
            rail = 32'hFFFF;
          end
          r.resp_byte0 = RLEN_TWO;
          {r.resp_byte3, r.resp_byte4} = rail[15:0];
        end
        PID_VOLTAGE: begin
          r.resp_byte0 = RLEN_TWO;
          {r.resp_byte3, r.resp_byte4} = cur.module_voltage_mv;
        end
        PID_OIL: begin
          r.resp_byte0 = RLEN_ONE;
          r.resp_byte3 = rq.oil_raw + TEMP_OFS;
        end
        default: begin
          r.resp_byte0 = RLEN_TWO;
          r.resp_byte3 = cur.unsupported_fill;
          r.resp_byte4 = cur.unsupported_fill;
        end
      endcase
    end else if (rq.req_len == LEN_SHORT && rq.req_mode == MODE_VEHINFO &&
                 rq.req_pid_high == PID_VIN_SUPP) begin
      r.resp_byte0 = RLEN_TWO;
    end else if (rq.req_mode == MODE_EXT) begin
      r.resp_byte0 = RLEN_TWO;
      r.resp_byte1 = RSP_MODE22;
      r.resp_byte2 = rq.req_pid_high;
      r.resp_byte3 = rq.req_pid_low;
      if (rq.req_len == LEN_EXT && rq.req_pid_high == EXT_HI_A &&
          rq.req_pid_low == EXT_LO_A) begin
        r.resp_byte0 = RLEN_THREE;
      end else if (rq.req_len == LEN_EXT && rq.req_pid_high == EXT_HI_B &&
                   (rq.req_pid_low == EXT_LO_B0 || rq.req_pid_low == EXT_LO_B1)) begin
        r.resp_byte4 = EXT_DATA_B;
      end
    end else begin
      // fallback echoes the request bytes
      r.resp_byte0 = RLEN_TWO;
      r.resp_byte1 = rq.req_mode;
      r.resp_byte2 = rq.req_pid_high;
      r.resp_byte3 = rq.req_pid_low;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    resp_t want;
    resp_t got;
    if (!rst_ni) begin
      reply_q.delete();
      regs.module_voltage_mv = VOLTAGE_RESET;
      regs.unsupported_fill  = FILL_RESET;
      outstanding_o <= 0;
      mismatches_o  = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_MODULE_VOLTAGE: regs.module_voltage_mv = cfg_mon.data;
          CFG_UNSUPP_FILL:    regs.unsupported_fill  = cfg_mon.data[7:0];
          default: ;
        endcase
      end
      if (req_mon.valid && req_mon.ready) begin
        reply_q.push_back(predict_reply(req_mon.data, regs));
      end
      if (resp_mon.valid && resp_mon.ready) begin
        got = resp_mon.data;
        if (reply_q.size() == 0) begin
          $display("%0t: reply word with none expected, got %016h", $time, got);
          mismatches_o++;
        end else begin
          want = reply_q.pop_front();
          for (int k = 0; k < 8; k++) begin
            if (got[63-8*k -: 8] !== want[63-8*k -: 8]) begin
              $display("%0t: resp_byte%0d mismatch, expected %02h, actual %02h",
                       $time, k, want[63-8*k -: 8], got[63-8*k -: 8]);
              mismatches_o++;
            end
          end
        end
      end
      outstanding_o <= reply_q.size();
    end
  end

endmodule

// ===== bench/obd2_pid_request_responder_unit_tb.sv =====
// ----------------------------------------------------------------------------
// obd2_pid_request_responder_unit_tb
// Drives requests and register writes into the OBD-II responder under random
// stalls on both sides, with one long reply stall that backs up the pipeline.
// A directed set covers every PID and the encoding corner cases; random
// requests follow under several register settings. The checker compares.
// ----------------------------------------------------------------------------
module obd2_pid_request_responder_unit_tb import obd2pr_pkg::*;;

  localparam int unsigned NumPhases     = 6;
  localparam int unsigned ItemsPerPhase = 296;
  localparam int unsigned SettleCycles  = 6;
  localparam int unsigned HoldCycles    = 60;
  localparam int unsigned WatchdogLimit = 2000;

  localparam logic [7:0] MODE01_PIDS [15] = '{
    PID_SUPP_00, PID_SUPP_20, PID_SUPP_40, PID_SUPP_60, PID_SUPP_80,
    PID_COOLANT, PID_FUEL_P, PID_MAP, PID_RPM, PID_SPEED, PID_IAT,
    PID_THROTTLE, PID_RAIL, PID_VOLTAGE, PID_OIL
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned outstanding;
  int unsigned mismatches;
  int unsigned quiet_cycles;
  bit          idle_on;
  bit          hold_reply;

  obd2pr_req_if  req_if ();
  obd2pr_resp_if resp_if ();
  obd2pr_cfg_if  cfg_if ();

  obd2_pid_request_responder_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .resp_o (resp_if),
    .cfg_i  (cfg_if)
  );

  obd2pr_reply_checker checker_u (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_mon       (req_if),
    .resp_mon      (resp_if),
    .cfg_mon       (cfg_if),
    .outstanding_o (outstanding),
    .mismatches_o  (mismatches)
  );

  always #5 clk_i = ~clk_i;

  function automatic req_t random_request();
    req_t        rq;
    int unsigned pick;
    rq.req_len            = 8'($urandom);
    rq.req_mode           = 8'($urandom);
    rq.req_pid_high       = 8'($urandom);
    rq.req_pid_low        = 8'($urandom);
    rq.manifold_gauge_kpa = 8'($urandom);
    rq.engine_rpm         = 16'($urandom);
    rq.vehicle_speed      = 8'($urandom);
    rq.throttle_pos       = 8'($urandom);
    rq.coolant_raw        = 8'($urandom);
    rq.oil_raw            = 8'($urandom);
    rq.fuel_pressure      = 16'($urandom);
    rq.intake_air_raw     = 8'($urandom);
    // lean on the map clamp edge and the rail saturation edge
    if ($urandom_range(0, 3) == 0) begin
      rq.manifold_gauge_kpa = 8'(int'(MAP_FLOOR) + int'($urandom_range(0, 6)) - 3);
    end
    case ($urandom_range(0, 2))
      0: rq.fuel_pressure = 16'(int'(RAIL_LIMIT) + int'($urandom_range(0, 8)) - 4);
      1: rq.fuel_pressure = 16'($urandom_range(0, RAIL_LIMIT));
      default: ;
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      rq.req_len      = LEN_SHORT;
      rq.req_mode     = MODE_CURRENT;
      rq.req_pid_high = MODE01_PIDS[$urandom_range(0, $size(MODE01_PIDS) - 1)];
    end else if (pick < 65) begin
      rq.req_len  = LEN_SHORT;
      rq.req_mode = MODE_CURRENT;
    end else if (pick < 72) begin
      if ($urandom_range(0, 3) != 0) begin
        rq.req_len = LEN_SHORT;
      end
      rq.req_mode = MODE_VEHINFO;
      if ($urandom_range(0, 1) == 0) begin
        rq.req_pid_high = PID_VIN_SUPP;
      end
    end else if (pick < 87) begin
      if ($urandom_range(0, 3) != 0) begin
        rq.req_len = LEN_EXT;
      end
      rq.req_mode = MODE_EXT;
      case ($urandom_range(0, 3))
        0: {rq.req_pid_high, rq.req_pid_low} = {EXT_HI_A, EXT_LO_A};
        1: {rq.req_pid_high, rq.req_pid_low} = {EXT_HI_B, EXT_LO_B0};
        2: {rq.req_pid_high, rq.req_pid_low} = {EXT_HI_B, EXT_LO_B1};
        default: ;
      endcase
    end
    return rq;
  endfunction

  function automatic req_t build_request(input logic [7:0] len, input logic [7:0] mode,
                                         input logic [7:0] pid_hi, input logic [7:0] pid_lo);
    req_t rq;
    rq = random_request();
    rq.req_len      = len;
    rq.req_mode     = mode;
    rq.req_pid_high = pid_hi;
    rq.req_pid_low  = pid_lo;
    return rq;
  endfunction

  task automatic send_request(input req_t rq);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= rq;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  task automatic write_register(input logic [CfgIdxW-1:0] idx,
                                input logic [CfgDataW-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
  endtask

  // stop offering, wait for every expected reply, then let the pipe go quiet
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // reply side
  initial begin
    resp_if.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_reply) begin
        hold_reply = 1'b0;
        resp_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        resp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end else begin
        resp_if.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (resp_if.valid && resp_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    req_t rq;
    rst_ni       <= 1'b0;
    req_if.valid <= 1'b0;
    req_if.data  <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= '0;
    cfg_if.data  <= '0;
    idle_on    = 1'b1;
    hold_reply = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int unsigned phase = 0; phase < NumPhases; phase++) begin
      if (phase == 0) begin
        // directed words under the reset register values
        send_request(build_request(LEN_SHORT, MODE_CURRENT, PID_SUPP_00, 8'h00));
        send_request(build_request(LEN_SHORT, MODE_CURRENT, PID_SUPP_20, 8'hFF));
        send_request(build_request(LEN_SHORT, MODE_CURRENT, PID_SUPP_40, 8'h00));
        send_request(build_request(LEN_SHORT, MODE_CURRENT, PID_SUPP_60, 8'h00));
        send_request(build_request(LEN_SHORT, MODE_CURRENT, PID_SUPP_80, 8'h00));
        rq = build_request(LEN_SHORT, MODE_CURRENT, PID_COOLANT, 8'h00);
        rq.coolant_raw = 8'hFF;
        send_request(rq);
        rq = build_request(LEN_SHORT, MODE_CURRENT, PID_FUEL_P, 8'h00);
        rq.fuel_pressure = 16'hFFFF;
        send_request(rq);
        rq = build_request(LEN_SHORT, MODE_CURRENT, PID_MAP, 8'h00);
        rq.manifold_gauge_kpa = -8'sd128;
        send_request(rq);
        rq.manifold_gauge_kpa = MAP_FLOOR;
        send_request(rq);
        rq.manifold_gauge_kpa = MAP_FLOOR + 8'sd1;
        send_request(rq);
        rq.manifold_gauge_kpa = 8'sd127;
        send_request(rq);
        rq = build_request(LEN_SHORT, MODE_CURRENT, PID_RPM, 8'h00);
        rq.engine_rpm = 16'hFFFF;
        send_request(rq);
        rq = build_request(LEN_SHORT, MODE_CURRENT, PID_SPEED, 8'h00);
        rq.vehicle_speed = 8'hFF;
        send_request(rq);
        rq = build_request(LEN_SHORT, MODE_CURRENT, PID_IAT, 8'h00);
        rq.intake_air_raw = 8'hFF;
        send_request(rq);
        rq = build_request(LEN_SHORT, MODE_CURRENT, PID_THROTTLE, 8'h00);
        rq.throttle_pos = 8'hFF;
        send_request(rq);
        rq = build_request(LEN_SHORT, MODE_CURRENT, PID_RAIL, 8'h00);
        rq.fuel_pressure = RAIL_LIMIT;
        send_request(rq);
        rq.fuel_pressure = RAIL_LIMIT + 16'd1;
        send_request(rq);
        rq.fuel_pressure = 16'hFFFF;
        send_request(rq);
        send_request(build_request(LEN_SHORT, MODE_CURRENT, PID_VOLTAGE, 8'h00));
        rq = build_request(LEN_SHORT, MODE_CURRENT, PID_OIL, 8'h00);
        rq.oil_raw = 8'hFF;
        send_request(rq);
        send_request(build_request(LEN_SHORT, MODE_CURRENT, 8'hFF, 8'hFF));
        send_request(build_request(LEN_SHORT, MODE_VEHINFO, PID_VIN_SUPP, 8'h00));
        send_request(build_request(LEN_EXT, MODE_EXT, EXT_HI_A, EXT_LO_A));
        send_request(build_request(LEN_EXT, MODE_EXT, EXT_HI_B, EXT_LO_B0));
        send_request(build_request(LEN_EXT, MODE_EXT, EXT_HI_B, EXT_LO_B1));
        send_request(build_request(LEN_SHORT, MODE_EXT, EXT_HI_A, EXT_LO_A));
        send_request(build_request(8'hFF, 8'h00, 8'hFF, 8'hFF));
      end else begin
        wait_drained();
        case (phase)
          1: begin
            write_register(CFG_MODULE_VOLTAGE, '0);
            write_register(CFG_UNSUPP_FILL, '0);
          end
          2: begin
            write_register(CFG_MODULE_VOLTAGE, '1);
            write_register(CFG_UNSUPP_FILL, '1);
          end
          3: begin
            write_register(CFG_MODULE_VOLTAGE, CfgDataW'($urandom));
            write_register(CFG_UNSUPP_FILL, CfgDataW'($urandom));
            // an unmapped index must leave both registers alone
            write_register(CfgIdxW'($urandom_range(CFG_UNSUPP_FILL + 1, 255)),
                           CfgDataW'($urandom));
          end
          default: begin
            write_register(CFG_MODULE_VOLTAGE, CfgDataW'($urandom));
            write_register(CFG_UNSUPP_FILL, CfgDataW'($urandom));
          end
        endcase
        cfg_if.valid <= 1'b0;
      end

      for (int unsigned n = 0; n < ItemsPerPhase; n++) begin
        if (n % 50 == 0) begin
          idle_on = (phase != NumPhases - 1) && ($urandom_range(0, 3) != 0);
        end
        if (phase == 2 && n == 100) begin
          // long reply stall while words keep coming
          idle_on    = 1'b0;
          hold_reply = 1'b1;
        end
        send_request(random_request());
      end
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/obd2pr_pkg.sv
hdl/obd2pr_if.sv
hdl/obd2pr_encoder.sv
hdl/obd2_pid_request_responder_unit.sv
bench/obd2pr_reply_checker.sv
bench/obd2_pid_request_responder_unit_tb.sv
